[sv/ils_pkg.sv]
// Shared types, constants and the switch debounce step for the launch sequencer.
package ils_pkg;

  localparam int NumPads        = 5;
  localparam int TicksPerSecond = 1000;
  localparam int NumSwitches    = 4;

  localparam int CountdownW = 7;
  localparam int DebounceW  = 10;
  localparam int TickW      = 10;
  localparam int SecondsW   = 7;
  localparam int PadIdxW    = 3;
  localparam int PadW       = 5;
  localparam int CfgDataW   = 10;

  localparam logic [DebounceW-1:0] CountMax   = '1;
  localparam logic [TickW-1:0]     TickLast   = TickW'(TicksPerSecond - 1);
  localparam logic [SecondsW-1:0]  SecondsMax = '1;
  localparam logic [PadIdxW-1:0]   PadsDone   = PadIdxW'(NumPads);

  // Configuration register indexes
  typedef enum logic {
    REG_COUNTDOWN = 1'b0,
    REG_DEBOUNCE  = 1'b1
  } cfg_reg_t;

  // Debouncer slots
  typedef enum logic [1:0] {
    SW_KEY    = 2'd0,
    SW_ENABLE = 2'd1,
    SW_LAUNCH = 2'd2,
    SW_ESTOP  = 2'd3
  } switch_t;

  typedef struct packed {
    logic                 key_level;
    logic                 enable_level;
    logic                 launch_level;
    logic                 estop_level;
    logic [PadW-1:0]      pad_levels;
  } item_t;

  typedef struct packed {
    logic                 system_on;
    logic                 stopped;
    logic                 launch_enabled;
    logic                 sequence_running;
    logic [PadIdxW-1:0]   current_pad;
    logic                 countdown_active;
    logic [SecondsW-1:0]  seconds_remaining;
    logic [SecondsW-1:0]  pad_seconds;
    logic                 fire;
    logic [PadIdxW-1:0]   fire_pad;
    logic                 connect_request;
  } result_t;

  typedef struct packed {
    logic                 last;
    logic [DebounceW-1:0] count;
    logic                 stable;
    logic                 accepted;
  } debounce_t;

  // One tick of a debouncer that tracks the last raw reading.
  function automatic debounce_t debounce_step(
    input logic                 raw,
    input logic                 last,
    input logic [DebounceW-1:0] count,
    input logic                 stable,
    input logic [DebounceW-1:0] thresh
  );
    debounce_t d;
    d.last     = last;
    d.count    = count;
    d.stable   = stable;
    d.accepted = 1'b0;
    if (raw != last) begin
      d.last  = raw;
      d.count = '0;
    end else if (count != CountMax) begin
      d.count = count + 1'b1;
    end
    if ((d.count >= thresh) && (raw != stable)) begin
      d.stable   = raw;
      d.accepted = 1'b1;
    end
    return d;
  endfunction

endpackage

[sv/interlocked_launch_sequencer_unit.sv]
// Top level of the interlocked launch sequencer: debouncers, latches and pad sequencer.
//
// A tick beat taken into the input register passes through one pass of logic
// into the result register, where it appears as a result beat.
// One tick beat is taken per cycle unless out_stall holds the result beat.
// Reset (rst, synchronous, active high): latches, sequencer and debouncers are
// cleared, switches read as released, countdown 5 s and debounce 50 ticks.
module interlocked_launch_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  // tick channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           key_level,
  input  logic                           enable_level,
  input  logic                           launch_level,
  input  logic                           estop_level,
  input  logic [ils_pkg::PadW-1:0]       pad_levels,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           system_on,
  output logic                           stopped,
  output logic                           launch_enabled,
  output logic                           sequence_running,
  output logic [ils_pkg::PadIdxW-1:0]    current_pad,
  output logic                           countdown_active,
  output logic [ils_pkg::SecondsW-1:0]   seconds_remaining,
  output logic [ils_pkg::SecondsW-1:0]   pad_seconds,
  output logic                           fire,
  output logic [ils_pkg::PadIdxW-1:0]    fire_pad,
  output logic                           connect_request,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [ils_pkg::CfgDataW-1:0]   cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ils_pkg::CountdownW-1:0] countdown_seconds;
  logic [ils_pkg::DebounceW-1:0]  debounce_ticks;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic                           stop_latch,        stop_latch_next;
  logic                           power_on,          power_on_next;
  logic                           armed,             armed_next;
  logic                           running,           running_next;
  logic [ils_pkg::PadIdxW-1:0]    pad_index,         pad_index_next;
  logic                           countdown_started, countdown_started_next;
  logic [ils_pkg::TickW-1:0]      sub_second_ticks,  sub_second_ticks_next;
  logic [ils_pkg::SecondsW-1:0]   elapsed_seconds,   elapsed_seconds_next;
  logic [ils_pkg::PadW-1:0]       pad_levels_held,   pad_levels_held_next;

  // Debouncer state, one slot per switch
  logic                           sw_stable   [ils_pkg::NumSwitches];
  logic                           sw_last_raw [ils_pkg::NumSwitches];
  logic [ils_pkg::DebounceW-1:0]  sw_count    [ils_pkg::NumSwitches];

  // ---------------------------------------------------------------------------
  // Pipeline: input register -> step logic -> result register
  // ---------------------------------------------------------------------------
  ils_pkg::item_t   s1_item;
  logic             s1_valid;
  ils_pkg::result_t res, res_next;
  logic             out_advance;
  logic             step;

  // Result register frees when empty or being taken this cycle.
  assign out_advance = !out_valid || !out_stall;
  // A tick held in the input register is retired into the result register.
  assign step        = s1_valid && out_advance;
  // Input register is free unless it holds a tick that cannot move on.
  assign in_stall    = s1_valid && !out_advance;
  assign cfg_ready   = 1'b1;

  // Every debouncer is evaluated each tick; the stop latch decides below
  // whether the key, enable and launch slots keep their update.
  ils_pkg::debounce_t db_estop, db_key, db_enable, db_launch;

  assign db_estop  = ils_pkg::debounce_step(s1_item.estop_level,
                       sw_last_raw[ils_pkg::SW_ESTOP], sw_count[ils_pkg::SW_ESTOP],
                       sw_stable[ils_pkg::SW_ESTOP], debounce_ticks);
  assign db_key    = ils_pkg::debounce_step(s1_item.key_level,
                       sw_last_raw[ils_pkg::SW_KEY], sw_count[ils_pkg::SW_KEY],
                       sw_stable[ils_pkg::SW_KEY], debounce_ticks);
  assign db_enable = ils_pkg::debounce_step(s1_item.enable_level,
                       sw_last_raw[ils_pkg::SW_ENABLE], sw_count[ils_pkg::SW_ENABLE],
                       sw_stable[ils_pkg::SW_ENABLE], debounce_ticks);
  assign db_launch = ils_pkg::debounce_step(s1_item.launch_level,
                       sw_last_raw[ils_pkg::SW_LAUNCH], sw_count[ils_pkg::SW_LAUNCH],
                       sw_stable[ils_pkg::SW_LAUNCH], debounce_ticks);

  // Held pad levels widened to the pad index range; missing pads read as armed.
  logic [(1 << ils_pkg::PadIdxW)-1:0] pads_wide;
  logic                               pad_armed;
  logic                               seq_enable;

  assign pads_wide = {{((1 << ils_pkg::PadIdxW) - ils_pkg::PadW){1'b0}},
                      pad_levels_held_next};

  always_comb begin
    stop_latch_next        = stop_latch;
    power_on_next          = power_on;
    armed_next             = armed;
    running_next           = running;
    pad_index_next         = pad_index;
    countdown_started_next = countdown_started;
    sub_second_ticks_next  = sub_second_ticks;
    elapsed_seconds_next   = elapsed_seconds;
    pad_levels_held_next   = pad_levels_held;
    pad_armed              = 1'b0;
    seq_enable             = 1'b0;
    res_next               = '0;

    // Emergency stop: a press edge toggles the latch; setting it halts a run.
    if (db_estop.accepted && !db_estop.stable) begin
      stop_latch_next = !stop_latch;
      if (stop_latch_next) begin
        running_next = 1'b0;
      end
    end

    if (!stop_latch_next) begin
      // Key: on powers up (and asks for a link), off drops power, arming and any run.
      if (db_key.accepted) begin
        if (!db_key.stable) begin
          if (!power_on_next) begin
            power_on_next            = 1'b1;
            res_next.connect_request = 1'b1;
          end
        end else begin
          power_on_next = 1'b0;
          armed_next    = 1'b0;
          running_next  = 1'b0;
        end
      end

      // Enable acts even with power off.
      if (db_enable.accepted) begin
        armed_next = !db_enable.stable;
      end

      if (power_on_next) begin
        pad_levels_held_next = s1_item.pad_levels;
      end

      // Launch press starts a fresh run from pad 0.
      if (db_launch.accepted && armed_next && !db_launch.stable && !running_next) begin
        running_next           = 1'b1;
        pad_index_next         = '0;
        countdown_started_next = 1'b0;
        sub_second_ticks_next  = '0;
        elapsed_seconds_next   = '0;
      end

      seq_enable = running_next;
    end

    // One sequencer step
    if (seq_enable) begin
      if (pad_index_next < ils_pkg::PadsDone) begin
        pad_armed = !pads_wide[pad_index_next];
        if (pad_armed) begin
          if (!countdown_started_next) begin
            countdown_started_next = 1'b1;
            sub_second_ticks_next  = '0;
            elapsed_seconds_next   = '0;
          end
          // Time left is positive exactly while whole seconds elapsed are short
          // of the countdown; the sub-second part only trims the floor by one.
          if (countdown_seconds > elapsed_seconds_next) begin
            res_next.countdown_active  = 1'b1;
            res_next.seconds_remaining = countdown_seconds - elapsed_seconds_next
                                         - ils_pkg::SecondsW'(sub_second_ticks_next != '0);
            res_next.pad_seconds       = elapsed_seconds_next;
            if (sub_second_ticks_next == ils_pkg::TickLast) begin
              sub_second_ticks_next = '0;
              if (elapsed_seconds_next != ils_pkg::SecondsMax) begin
                elapsed_seconds_next = elapsed_seconds_next + 1'b1;
              end
            end else begin
              sub_second_ticks_next = sub_second_ticks_next + 1'b1;
            end
          end else begin
            res_next.fire          = 1'b1;
            res_next.fire_pad      = pad_index_next;
            pad_index_next         = pad_index_next + 1'b1;
            countdown_started_next = 1'b0;
          end
        end else begin
          // Unarmed pad is skipped.
          pad_index_next         = pad_index_next + 1'b1;
          countdown_started_next = 1'b0;
        end
      end else begin
        running_next = 1'b0;
      end
    end

    res_next.system_on        = power_on_next;
    res_next.stopped          = stop_latch_next;
    res_next.launch_enabled   = armed_next;
    res_next.sequence_running = running_next;
    res_next.current_pad      = pad_index_next;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      countdown_seconds <= ils_pkg::CountdownW'(5);
      debounce_ticks    <= ils_pkg::DebounceW'(50);
      stop_latch        <= 1'b0;
      power_on          <= 1'b0;
      armed             <= 1'b0;
      running           <= 1'b0;
      pad_index         <= '0;
      countdown_started <= 1'b0;
      sub_second_ticks  <= '0;
      elapsed_seconds   <= '0;
      pad_levels_held   <= '0;
      for (int i = 0; i < ils_pkg::NumSwitches; i++) begin
        sw_stable[i]   <= 1'b1;
        sw_last_raw[i] <= 1'b1;
        sw_count[i]    <= '0;
      end
    end else begin
      // input register
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
        s1_item  <= '{key_level:    key_level,
                      enable_level: enable_level,
                      launch_level: launch_level,
                      estop_level:  estop_level,
                      pad_levels:   pad_levels};
      end else if (out_advance) begin
        s1_valid <= 1'b0;
      end

      // result register
      if (out_advance) begin
        out_valid <= s1_valid;
      end

      if (step) begin
        res               <= res_next;
        stop_latch        <= stop_latch_next;
        power_on          <= power_on_next;
        armed             <= armed_next;
        running           <= running_next;
        pad_index         <= pad_index_next;
        countdown_started <= countdown_started_next;
        sub_second_ticks  <= sub_second_ticks_next;
        elapsed_seconds   <= elapsed_seconds_next;
        pad_levels_held   <= pad_levels_held_next;

        sw_last_raw[ils_pkg::SW_ESTOP] <= db_estop.last;
        sw_count[ils_pkg::SW_ESTOP]    <= db_estop.count;
        sw_stable[ils_pkg::SW_ESTOP]   <= db_estop.stable;
        // Other debouncers freeze while the stop latch is set.
        if (!stop_latch_next) begin
          sw_last_raw[ils_pkg::SW_KEY]    <= db_key.last;
          sw_count[ils_pkg::SW_KEY]       <= db_key.count;
          sw_stable[ils_pkg::SW_KEY]      <= db_key.stable;
          sw_last_raw[ils_pkg::SW_ENABLE] <= db_enable.last;
          sw_count[ils_pkg::SW_ENABLE]    <= db_enable.count;
          sw_stable[ils_pkg::SW_ENABLE]   <= db_enable.stable;
          sw_last_raw[ils_pkg::SW_LAUNCH] <= db_launch.last;
          sw_count[ils_pkg::SW_LAUNCH]    <= db_launch.count;
          sw_stable[ils_pkg::SW_LAUNCH]   <= db_launch.stable;
        end
      end

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (ils_pkg::cfg_reg_t'(cfg_index))
          ils_pkg::REG_COUNTDOWN: countdown_seconds <= cfg_data[ils_pkg::CountdownW-1:0];
          ils_pkg::REG_DEBOUNCE:  debounce_ticks    <= cfg_data[ils_pkg::DebounceW-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------------------
  assign system_on         = res.system_on;
  assign stopped           = res.stopped;
  assign launch_enabled    = res.launch_enabled;
  assign sequence_running  = res.sequence_running;
  assign current_pad       = res.current_pad;
  assign countdown_active  = res.countdown_active;
  assign seconds_remaining = res.seconds_remaining;
  assign pad_seconds       = res.pad_seconds;
  assign fire              = res.fire;
  assign fire_pad          = res.fire_pad;
  assign connect_request   = res.connect_request;

endmodule

[sv/ils_checker.sv]
// Port-level checks for the launch sequencer, bound to the top level.
module ils_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           system_on,
  input logic                           stopped,
  input logic                           sequence_running,
  input logic [ils_pkg::PadIdxW-1:0]    current_pad,
  input logic                           countdown_active,
  input logic                           fire,
  input logic [ils_pkg::PadIdxW-1:0]    fire_pad,
  input logic                           connect_request
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fire) && $stable(current_pad))
    else $error("result beat changed while stalled");

  // Firing happens only inside a run, never alongside a countdown, on a real pad.
  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fire |-> sequence_running && !countdown_active &&
                          (fire_pad < ils_pkg::PadsDone))
    else $error("fire outside a run or on a bad pad");

  // A set stop latch leaves nothing running.
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && stopped |-> !sequence_running && !countdown_active && !fire)
    else $error("sequence active while stopped");

  // A countdown beat means a run on a pad still to be done.
  a_countdown_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && countdown_active |-> sequence_running &&
                                      (current_pad < ils_pkg::PadsDone))
    else $error("countdown outside a run");

  // Connect request only comes with power on.
  a_connect_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && connect_request |-> system_on)
    else $error("connect request without power");

endmodule

bind interlocked_launch_sequencer_unit ils_checker u_ils_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .system_on        (system_on),
  .stopped          (stopped),
  .sequence_running (sequence_running),
  .current_pad      (current_pad),
  .countdown_active (countdown_active),
  .fire             (fire),
  .fire_pad         (fire_pad),
  .connect_request  (connect_request)
);
